/* sv/cxdc_pkg.sv */
// ----------------------------------------------------------------------------
// Chained XOR datagram cipher: shared types and constants
// Controller state, command and status groups, and the byte masks of the
// header rewrite.
// ----------------------------------------------------------------------------
package cxdc_pkg;

	typedef enum logic [1:0] {
		ST_ACCEPT,
		ST_FLUSH_RD,
		ST_FLUSH_WR
	} ctrl_state_t;

	localparam logic [7:0] FIRST_KEY_SET = 8'h01;
	localparam logic [7:0] LOW_BITS_MASK = 8'h07;
	localparam logic [7:0] ENC_TAG_SET   = 8'h08;
	localparam logic [7:0] CLEARED_BYTE  = 8'h00;
	localparam logic [4:0] DEC_TAG       = 5'h01;

	localparam logic OP_ENCRYPT   = 1'b0;
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_SHORT = 1'b1;

	typedef struct packed {
		logic first_beat;
		logic hdr_wr;
		logic hdr1_cap;
		logic chain_init;
		logic emit_stream;
		logic stream_last;
		logic emit_flush;
		logic flush_final;
		logic flush_short;
		logic pos_is1;
		logic pos_is_key;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

/* sv/cxdc_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module cxdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 14
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/cxdc_datapath.sv */
// ----------------------------------------------------------------------------
// Chained XOR datagram cipher: datapath
// Header store, message latches, running chain key and the output register.
// ----------------------------------------------------------------------------
module cxdc_datapath #(
	parameter int KEY_POSITION = 13
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cxdc_pkg::dp_cmd_t                   cmd,
	output cxdc_pkg::dp_stat_t                  stat,
	input  logic [$clog2(KEY_POSITION+1)-1:0]   wr_addr,
	input  logic [$clog2(KEY_POSITION+1)-1:0]   rd_addr,
	input  logic                                op,
	input  logic [7:0]                          data_byte,
	input  logic [7:0]                          fresh_key,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [7:0]                          out_byte,
	output logic                                out_last,
	output logic                                status
);
	import cxdc_pkg::*;

	localparam int HDR_LEN = KEY_POSITION + 1;

	logic [7:0] hdr_rd;
	logic       mode_q;
	logic [7:0] key_q;
	logic [4:0] hdr1_tag_q;
	logic       bypass_q;
	logic [7:0] chain_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       status_q;
	logic [7:0] stream_res;
	logic [7:0] flush_res;
	logic       flush_chains;

	cxdc_ram #(
		.WIDTH(8),
		.DEPTH(HDR_LEN)
	) u_hdr_ram (
		.clk  (clk),
		.we   (cmd.hdr_wr),
		.waddr(wr_addr),
		.wdata(data_byte),
		.raddr(rd_addr),
		.rdata(hdr_rd)
	);

	always_comb begin
		stream_res = bypass_q ? data_byte : (data_byte ^ chain_q);
	end

	always_comb begin
		flush_chains = 1'b0;
		priority if (cmd.flush_short || bypass_q) begin
			flush_res = hdr_rd;
		end else if (cmd.pos_is1) begin
			flush_res = (mode_q == OP_ENCRYPT) ? (hdr_rd | ENC_TAG_SET)
			                                   : (hdr_rd & LOW_BITS_MASK);
		end else if (cmd.pos_is_key) begin
			flush_res = (mode_q == OP_ENCRYPT) ? key_q : CLEARED_BYTE;
		end else begin
			flush_res    = hdr_rd ^ chain_q;
			flush_chains = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= OP_ENCRYPT;
			key_q      <= '0;
			hdr1_tag_q <= '0;
			bypass_q   <= 1'b0;
			chain_q    <= '0;
		end else begin
			if (cmd.first_beat) begin
				mode_q   <= op;
				key_q    <= fresh_key;
				bypass_q <= 1'b0;
			end
			if (cmd.hdr1_cap) begin
				hdr1_tag_q <= data_byte[7:3];
			end
			if (cmd.chain_init) begin
				bypass_q <= (mode_q != OP_ENCRYPT) && (hdr1_tag_q != DEC_TAG);
				chain_q  <= (mode_q == OP_ENCRYPT) ? (key_q | FIRST_KEY_SET)
				                                   : (data_byte | FIRST_KEY_SET);
			end
			// Decryption chains on the ciphertext, encryption on its own output.
			if (cmd.emit_stream && !bypass_q) begin
				chain_q <= (mode_q == OP_ENCRYPT) ? stream_res : data_byte;
			end
			if (cmd.emit_flush && flush_chains) begin
				chain_q <= (mode_q == OP_ENCRYPT) ? flush_res : hdr_rd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_stream || cmd.emit_flush) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_stream) begin
			out_byte_q <= stream_res;
			out_last_q <= cmd.stream_last;
			status_q   <= STATUS_OK;
		end else if (cmd.emit_flush) begin
			out_byte_q <= flush_res;
			out_last_q <= cmd.flush_final;
			status_q   <= cmd.flush_short ? STATUS_SHORT : STATUS_OK;
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign out_last      = out_last_q;
	assign status        = status_q;

`ifndef SYNTHESIS
	a_emit_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_stream || cmd.emit_flush) |-> (!out_valid_q || out_ready))
		else $error("result loaded while the output register still held a beat");
	a_single_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_stream && cmd.emit_flush))
		else $error("stream and flush results loaded in the same cycle");
`endif

endmodule

/* sv/cxdc_ctrl.sv */
// ----------------------------------------------------------------------------
// Chained XOR datagram cipher: controller
// Counts header beats, sequences the header flush and issues datapath commands.
// ----------------------------------------------------------------------------
module cxdc_ctrl #(
	parameter int KEY_POSITION = 13
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              last,
	input  cxdc_pkg::dp_stat_t                stat,
	output cxdc_pkg::dp_cmd_t                 cmd,
	output logic [$clog2(KEY_POSITION+1)-1:0] wr_addr,
	output logic [$clog2(KEY_POSITION+1)-1:0] rd_addr
);
	import cxdc_pkg::*;

	localparam int HDR_LEN = KEY_POSITION + 1;
	localparam int AW      = $clog2(HDR_LEN);
	localparam int CW      = $clog2(HDR_LEN + 1);

	ctrl_state_t   state_q;
	ctrl_state_t   state_d;
	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] len_m1_q;
	logic          short_q;
	logic          msg_last_q;
	logic          take;
	logic          in_hdr;
	logic          hdr_full;
	logic          flush_end;

	assign in_hdr    = count_q < CW'(HDR_LEN);
	assign hdr_full  = count_q == CW'(HDR_LEN - 1);
	assign flush_end = idx_q == len_m1_q;
	assign take      = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_ACCEPT: begin
				if (take && in_hdr && (hdr_full || last)) begin
					state_d = ST_FLUSH_RD;
				end
			end
			ST_FLUSH_RD: begin
				state_d = ST_FLUSH_WR;
			end
			ST_FLUSH_WR: begin
				if (stat.out_free) begin
					state_d = flush_end ? ST_ACCEPT : ST_FLUSH_RD;
				end
			end
			default: begin
				state_d = ST_ACCEPT;
			end
		endcase
	end

	always_comb begin
		in_ready         = (state_q == ST_ACCEPT) && stat.out_free;
		cmd.first_beat   = take && (count_q == '0);
		cmd.hdr_wr       = take && in_hdr;
		cmd.hdr1_cap     = take && (count_q == CW'(1));
		cmd.chain_init   = take && hdr_full;
		cmd.emit_stream  = take && !in_hdr;
		cmd.stream_last  = last;
		cmd.emit_flush   = (state_q == ST_FLUSH_WR) && stat.out_free;
		cmd.flush_final  = msg_last_q && flush_end;
		cmd.flush_short  = short_q;
		cmd.pos_is1      = idx_q == AW'(1);
		cmd.pos_is_key   = idx_q == AW'(KEY_POSITION);
		wr_addr          = count_q[AW-1:0];
		rd_addr          = idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_ACCEPT;
			count_q    <= '0;
			idx_q      <= '0;
			len_m1_q   <= '0;
			short_q    <= 1'b0;
			msg_last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				if (in_hdr) begin
					if (hdr_full) begin
						len_m1_q   <= AW'(HDR_LEN - 1);
						short_q    <= 1'b0;
						msg_last_q <= last;
						idx_q      <= '0;
					end else if (last) begin
						// A short message is returned as it was buffered.
						len_m1_q   <= count_q[AW-1:0];
						short_q    <= 1'b1;
						msg_last_q <= 1'b1;
						idx_q      <= '0;
					end
					count_q <= last ? '0 : count_q + CW'(1);
				end else if (last) begin
					count_q <= '0;
				end
			end
			if ((state_q == ST_FLUSH_WR) && stat.out_free && !flush_end) begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(HDR_LEN))
		else $error("byte count ran past the header length");
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ACCEPT) |-> (idx_q <= len_m1_q))
		else $error("flush index ran past the buffered length");
	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH_WR) |->
			($past(state_q) == ST_FLUSH_RD || $past(state_q) == ST_FLUSH_WR))
		else $error("flush output step entered without a header read");
`endif

endmodule

/* sv/chained_xor_datagram_cipher.sv */
// ----------------------------------------------------------------------------
// Chained XOR datagram cipher
// Encrypts or decrypts a datagram byte by byte with a ciphertext-chained key.
// ----------------------------------------------------------------------------
// Usage: bytes enter on the in_valid/in_ready channel with op, fresh_key and
// last; op and fresh_key count only on the first beat of a message. Results
// leave on the out_valid/out_ready channel with out_last and status.
// The first KEY_POSITION+1 bytes are held in a small RAM and produce no
// output until the byte at KEY_POSITION arrives (or last, for a short
// message). The header is then replayed from the RAM, each byte taking a
// registered RAM read step and then a step that loads the output register;
// input is held off during this replay. After the header each byte appears
// in the output register the cycle after it is accepted, so a long message
// streams at one byte per cycle while the receiver keeps taking beats.
// A short message comes back unchanged with status 1 on every beat.
// When the receiver stalls, the output register holds its beat and in_ready
// falls until it is taken. Reset (arst_n low) empties the output register
// and starts a new message; no RAM clearing is needed.
// ----------------------------------------------------------------------------
module chained_xor_datagram_cipher #(
	parameter int KEY_POSITION = 13
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       op,
	input  logic [7:0] data_byte,
	input  logic       last,
	input  logic [7:0] fresh_key,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       status
);
	import cxdc_pkg::*;

	localparam int AW = $clog2(KEY_POSITION + 1);

	dp_cmd_t       cmd;
	dp_stat_t      stat;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	cxdc_ctrl #(
		.KEY_POSITION(KEY_POSITION)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.last    (last),
		.stat    (stat),
		.cmd     (cmd),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr)
	);

	cxdc_datapath #(
		.KEY_POSITION(KEY_POSITION)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr),
		.op       (op),
		.data_byte(data_byte),
		.fresh_key(fresh_key),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte (out_byte),
		.out_last (out_last),
		.status   (status)
	);

endmodule
